FILE: design/pim_pkg.sv
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and constants for the PWM input measurement block.
// ----------------------------------------------------------------------------
package pim_pkg;
	localparam int unsigned RATE_W   = 24;
	localparam int unsigned TOP_W    = 16;
	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned DUTY_W   = 15;
	localparam int unsigned DUTY_MAX = 25600;
	localparam int unsigned DUTY_MUL = 25600;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP = 8'd1;

	// datapath commands from the controller
	typedef struct packed {
		logic tick;        // update counters with latched pins
		logic div_start;   // load divider for selected channel
		logic div_step;    // one quotient bit
		logic ch_next;     // advance channel pointer
		logic ch_clear;    // channel pointer to zero
	} pim_cmd_t;

	typedef struct packed {
		logic ch_emit;     // selected channel has a result this tick
		logic ch_last;     // pointer at final channel, or no emitting channel above it
		logic div_done;
		logic more_after;  // another emitting channel above pointer
	} pim_sts_t;
endpackage

FILE: design/pwm_input_measure_top.sv
// Per tick: counter update, then for each channel with a result a divider load and
// quotient steps (one quotient bit per cycle, shared by all channels), then the output
// handshake. The next tick is not taken until the last result has been emitted, and
// channels without a result are scanned and skipped; output stalls hold the sequence.
// Reset (arst_n low, asynchronous): counters, levels, captures cleared;
// tick_rate_hz = 1000000, counter_top = 65535.
// ----------------------------------------------------------------------------
// pwm_input_measure_top
// PWM period/duty/frequency capture for several pins, one item per timer tick.
// ----------------------------------------------------------------------------
module pwm_input_measure_top #(
	parameter int unsigned CHANNELS     = 3,
	parameter int unsigned COUNTER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [CHANNELS-1:0]           pin_levels,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(CHANNELS+1)-1:0] channel_index,
	output logic [15:0]                   period_ticks,
	output logic [15:0]                   pulse_ticks,
	output logic [14:0]                   duty_percent_q8,
	output logic [23:0]                   frequency_hz,
	output logic                          last_result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	pim_pkg::pim_cmd_t cmd;
	pim_pkg::pim_sts_t sts;
	logic [pim_pkg::RATE_W-1:0] rate_q;
	logic [pim_pkg::TOP_W-1:0]  top_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= pim_pkg::RATE_W'(1000000);
			top_q  <= pim_pkg::TOP_W'(65535);
		end else if (cfg_valid) begin
			if (cfg_index == pim_pkg::REG_TICK_RATE) rate_q <= cfg_data[23:0];
			else if (cfg_index == pim_pkg::REG_COUNTER_TOP) top_q <= cfg_data[15:0];
		end
	end

	pim_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
	);

	pim_dp #(.CHANNELS(CHANNELS), .COUNTER_BITS(COUNTER_BITS)) u_dp (
		.clk, .arst_n,
		.in_take(in_valid && !in_stall),
		.pin_levels,
		.tick_rate_hz(rate_q),
		.counter_top(top_q),
		.cmd, .sts,
		.channel_index, .period_ticks, .pulse_ticks,
		.duty_percent_q8, .frequency_hz, .last_result
	);
endmodule

FILE: design/pim_ctrl.sv
// ----------------------------------------------------------------------------
// pim_ctrl
// Sequencer: counter update, then per channel divide and emit.
// ----------------------------------------------------------------------------
module pim_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output pim_pkg::pim_cmd_t cmd,
	input  pim_pkg::pim_sts_t sts
);
	typedef enum logic [2:0] {IDLE, UPDATE, SCAN, DIV, EMIT} state_t;
	state_t state_q;

	assign in_stall = (state_q != IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:   cmd.ch_clear = 1'b1;
			UPDATE: cmd.tick = 1'b1;
			SCAN: begin
				if (sts.ch_emit) cmd.div_start = 1'b1;
				else cmd.ch_next = 1'b1;
			end
			DIV:    cmd.div_step = 1'b1;
			EMIT:   cmd.ch_next = !out_stall;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= UPDATE;
				UPDATE: state_q <= SCAN;
				SCAN: begin
					if (sts.ch_emit) state_q <= DIV;
					else if (sts.ch_last) state_q <= IDLE;
				end
				DIV: if (sts.div_done) begin
					state_q   <= EMIT;
					out_valid <= 1'b1;
				end
				EMIT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= sts.ch_last ? IDLE : SCAN;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: design/pim_dp.sv
// ----------------------------------------------------------------------------
// pim_dp
// Per-channel counters and captures, shared serial divider for
// duty and frequency.
// ----------------------------------------------------------------------------
module pim_dp #(
	parameter int unsigned CHANNELS     = 3,
	parameter int unsigned COUNTER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_take,
	input  logic [CHANNELS-1:0]                pin_levels,
	input  logic [pim_pkg::RATE_W-1:0]         tick_rate_hz,
	input  logic [pim_pkg::TOP_W-1:0]          counter_top,
	input  pim_pkg::pim_cmd_t                  cmd,
	output pim_pkg::pim_sts_t                  sts,
	output logic [$clog2(CHANNELS+1)-1:0]      channel_index,
	output logic [pim_pkg::FIELD_W-1:0]        period_ticks,
	output logic [pim_pkg::FIELD_W-1:0]        pulse_ticks,
	output logic [pim_pkg::DUTY_W-1:0]         duty_percent_q8,
	output logic [pim_pkg::RATE_W-1:0]         frequency_hz,
	output logic                               last_result
);
	localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned IDX_W = $clog2(CHANNELS+1);
	localparam int unsigned FW    = pim_pkg::FIELD_W;
	localparam int unsigned DN_W  = FW + 15;  // pulse*25600 < 2^31
	localparam int unsigned SC_W  = $clog2(DN_W+1);

	logic [CHANNELS-1:0]     pins_q;
	logic [COUNTER_BITS-1:0] cnt_q   [CHANNELS];
	logic [CHANNELS-1:0]     prior_q;
	logic [FW-1:0]           pulse_q [CHANNELS];
	logic [FW-1:0]           period_q[CHANNELS];
	logic [CHANNELS-1:0]     emit_q;
	logic [CH_W-1:0]         ch_q;

	logic [DN_W-1:0]  dnum_q;
	logic [DN_W-1:0]  dquo_q;
	logic [FW:0]      drem_q;
	logic [pim_pkg::RATE_W-1:0] fnum_q;
	logic [pim_pkg::RATE_W-1:0] fquo_q;
	logic [FW:0]      frem_q;
	logic [FW-1:0]    div_q;
	logic [SC_W-1:0]  cnt_step_q;

	always_ff @(posedge clk) if (in_take) pins_q <= pin_levels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
			emit_q  <= '0;
			for (int n = 0; n < CHANNELS; n++) begin
				cnt_q[n]    <= '0;
				pulse_q[n]  <= '0;
				period_q[n] <= '0;
			end
		end else if (cmd.tick) begin
			for (int n = 0; n < CHANNELS; n++) begin
				logic [COUNTER_BITS-1:0] c;
				logic rise, fall;
				rise = !prior_q[n] && pins_q[n];
				fall = prior_q[n] && !pins_q[n];
				if (cnt_q[n] >= COUNTER_BITS'(counter_top)) c = '0;
				else c = cnt_q[n] + 1'b1;
				emit_q[n]   <= 1'b0;
				if (rise) begin
					period_q[n] <= FW'(c);
					emit_q[n]   <= (FW'(c) != '0);
					c = '0;
				end else if (fall) begin
					pulse_q[n] <= FW'(c);
				end
				cnt_q[n]   <= c;
				prior_q[n] <= pins_q[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ch_q <= '0;
		else if (cmd.ch_clear) ch_q <= '0;
		else if (cmd.ch_next && ch_q != CH_W'(CHANNELS-1)) ch_q <= ch_q + 1'b1;
	end

	logic more;
	always_comb begin
		more = 1'b0;
		for (int n = 0; n < CHANNELS; n++)
			if (CH_W'(n) > ch_q && emit_q[n]) more = 1'b1;
	end

	// restoring division, duty and frequency together, one bit per step
	logic [FW:0] dtry, ftry;
	assign dtry = {drem_q[FW-1:0], dnum_q[DN_W-1]};
	assign ftry = {frem_q[FW-1:0], fnum_q[pim_pkg::RATE_W-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_step_q <= '0;
		else if (cmd.div_start) cnt_step_q <= '0;
		else if (cmd.div_step) cnt_step_q <= cnt_step_q + 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q  <= period_q[ch_q];
			dnum_q <= DN_W'(pulse_q[ch_q]) * DN_W'(pim_pkg::DUTY_MUL);
			fnum_q <= tick_rate_hz;
			drem_q <= '0;
			frem_q <= '0;
		end else if (cmd.div_step) begin
			dnum_q <= dnum_q << 1;
			if (dtry >= {1'b0, div_q}) begin
				drem_q <= dtry - {1'b0, div_q};
				dquo_q <= {dquo_q[DN_W-2:0], 1'b1};
			end else begin
				drem_q <= dtry;
				dquo_q <= {dquo_q[DN_W-2:0], 1'b0};
			end
			if (cnt_step_q < SC_W'(pim_pkg::RATE_W)) begin
				fnum_q <= fnum_q << 1;
				if (ftry >= {1'b0, div_q}) begin
					frem_q <= ftry - {1'b0, div_q};
					fquo_q <= {fquo_q[pim_pkg::RATE_W-2:0], 1'b1};
				end else begin
					frem_q <= ftry;
					fquo_q <= {fquo_q[pim_pkg::RATE_W-2:0], 1'b0};
				end
			end
		end
	end

	assign sts.ch_emit    = emit_q[ch_q];
	assign sts.ch_last    = (ch_q == CH_W'(CHANNELS-1)) || !more;
	assign sts.div_done   = (cnt_step_q == SC_W'(DN_W-1)) && cmd.div_step;
	assign sts.more_after = more;

	assign channel_index   = IDX_W'(ch_q);
	assign period_ticks    = div_q;
	assign pulse_ticks     = pulse_q[ch_q];
	assign duty_percent_q8 = (dquo_q > DN_W'(pim_pkg::DUTY_MAX)) ?
		pim_pkg::DUTY_W'(pim_pkg::DUTY_MAX) : dquo_q[pim_pkg::DUTY_W-1:0];
	assign frequency_hz    = fquo_q;
	assign last_result     = !sts.more_after;
endmodule

FILE: design/pim_checker.sv
// ----------------------------------------------------------------------------
// pim_checker
// Port-level checks for the PWM input measurement block.
// ----------------------------------------------------------------------------
module pim_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] period_ticks,
	input logic [14:0] duty_percent_q8
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(period_ticks))
		else $error("stalled result changed");
	a_period_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> period_ticks != 16'd0)
		else $error("zero period emitted");
	a_duty_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_percent_q8 <= 15'd25600)
		else $error("duty above 100 percent");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");
endmodule

bind pwm_input_measure_top pim_checker u_pim_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall,
	.period_ticks, .duty_percent_q8
);
